### sv/complex_horner_polynomial_eval_defines.svh
// assertion macros used by the checker file
// depends on nothing; guarded against double inclusion
`ifndef COMPLEX_HORNER_POLYNOMIAL_EVAL_DEFINES_SVH
`define COMPLEX_HORNER_POLYNOMIAL_EVAL_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CHPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chpe assertion failed");

// next-cycle implication, disabled while reset is low
`define CHPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chpe assertion failed");

`endif

### sv/chpe_pkg.sv
// shared constants and types of the complex horner polynomial evaluator
// no dependencies
package chpe_pkg;

    localparam int MAX_TERMS = 16;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int IDX_W     = 4;
    localparam int DEG_W     = 4;
    localparam int DATA_W    = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;    // latch z, clear result and flag, load step counter
        logic load;     // write one coefficient
        logic cfg_wr;   // write degree
        logic mul;      // form the four partial products
        logic acc;      // combine, add coefficient, step counter
        logic put;      // move result into output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;     // step counter at power zero
    } t_dp_sts;

endpackage

### sv/chpe_in_if.sv
// input channel: load or evaluate transactions
// depends on chpe_pkg
interface chpe_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [chpe_pkg::IDX_W-1:0]          index;
    logic signed [chpe_pkg::DATA_W-1:0]  value_re;
    logic signed [chpe_pkg::DATA_W-1:0]  value_im;

    modport source (output valid, output operation, output index,
                    output value_re, output value_im, input ready);
    modport sink   (input valid, input operation, input index,
                    input value_re, input value_im, output ready);
endinterface

### sv/chpe_out_if.sv
// output channel: polynomial values
// depends on chpe_pkg
interface chpe_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [chpe_pkg::DATA_W-1:0]  result_re;
    logic signed [chpe_pkg::DATA_W-1:0]  result_im;
    logic                                overflow;

    modport source (output valid, output result_re, output result_im,
                    output overflow, input ready);
    modport sink   (input valid, input result_re, input result_im,
                    input overflow, output ready);
endinterface

### sv/chpe_cfg_if.sv
// configuration write channel: degree register
// depends on chpe_pkg
interface chpe_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [chpe_pkg::DEG_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/chpe_ctrl.sv
// sequencer of the evaluator: handshakes and step order
// depends on chpe_pkg
module chpe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  chpe_pkg::t_dp_sts i_sts,
    output chpe_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_PUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_acc;
    logic   w_put;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    // result register free or being emptied this cycle
    assign w_put       = (r_state == S_PUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_op == chpe_pkg::OP_EVAL)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = i_sts.last ? S_PUT : S_MUL;
            S_PUT: begin
                if (w_put) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_put) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = w_in_acc && (i_in_op == chpe_pkg::OP_EVAL);
        o_cmd.load   = w_in_acc && (i_in_op == chpe_pkg::OP_LOAD);
        o_cmd.cfg_wr = i_cfg_valid;
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.acc    = (r_state == S_ACC);
        o_cmd.put    = w_put;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/chpe_dp.sv
// datapath: coefficient store, complex multiply-add, saturation, result register
// depends on chpe_pkg
module chpe_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chpe_pkg::t_dp_cmd                   i_cmd,
    output chpe_pkg::t_dp_sts                   o_sts,
    input  logic [chpe_pkg::DEG_W-1:0]          i_cfg_data,
    input  logic [chpe_pkg::IDX_W-1:0]          i_index,
    input  logic signed [chpe_pkg::DATA_W-1:0]  i_value_re,
    input  logic signed [chpe_pkg::DATA_W-1:0]  i_value_im,
    output logic signed [chpe_pkg::DATA_W-1:0]  o_result_re,
    output logic signed [chpe_pkg::DATA_W-1:0]  o_result_im,
    output logic                                o_overflow
);

    localparam int DW  = chpe_pkg::DATA_W;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW - 16 + 2;   // product sum width after the shift
    localparam int EXT = SW - DW;

    function automatic logic f_ovf(input logic [SW-1:0] x);
        return (x[SW-1:DW-1] != '0) && (x[SW-1:DW-1] != '1);
    endfunction

    function automatic logic [DW-1:0] f_sat(input logic [SW-1:0] x);
        logic [DW-1:0] v;
        if (f_ovf(x)) begin
            v = x[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            v = x[DW-1:0];
        end
        return v;
    endfunction

    logic [DW-1:0]   r_cre [chpe_pkg::MAX_TERMS];
    logic [DW-1:0]   r_cim [chpe_pkg::MAX_TERMS];
    logic [chpe_pkg::MAX_TERMS-1:0] r_cvld;

    logic [chpe_pkg::DEG_W-1:0]  r_degree;
    logic [chpe_pkg::ADDR_W-1:0] r_k;
    logic [chpe_pkg::ADDR_W-1:0] w_top;
    logic                        w_load_ok;

    logic signed [DW-1:0] r_z_re, r_z_im;
    logic signed [DW-1:0] r_res_re, r_res_im;
    logic                 r_ovf;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic [DW-1:0]        r_c_re, r_c_im;

    logic [SW-1:0] w_m_re_x, w_m_im_x, w_a_re_x, w_a_im_x;
    logic [DW-1:0] w_m_re, w_m_im;
    logic          w_step_ovf;

    assign w_load_ok = (int'(i_index) < chpe_pkg::MAX_TERMS);
    assign w_top = (int'(r_degree) > chpe_pkg::MAX_TERMS - 1)
                 ? chpe_pkg::ADDR_W'(chpe_pkg::MAX_TERMS - 1)
                 : chpe_pkg::ADDR_W'(r_degree);
    assign o_sts.last = (r_k == '0);

    // floor(product / 2^16) is the arithmetic shift of the full product
    assign w_m_re_x = {{2{r_p_rr[PW-1]}}, r_p_rr[PW-1:16]}
                    - {{2{r_p_ii[PW-1]}}, r_p_ii[PW-1:16]};
    assign w_m_im_x = {{2{r_p_ri[PW-1]}}, r_p_ri[PW-1:16]}
                    + {{2{r_p_ir[PW-1]}}, r_p_ir[PW-1:16]};
    assign w_m_re   = f_sat(w_m_re_x);
    assign w_m_im   = f_sat(w_m_im_x);
    assign w_a_re_x = {{EXT{w_m_re[DW-1]}}, w_m_re} + {{EXT{r_c_re[DW-1]}}, r_c_re};
    assign w_a_im_x = {{EXT{w_m_im[DW-1]}}, w_m_im} + {{EXT{r_c_im[DW-1]}}, r_c_im};
    assign w_step_ovf = f_ovf(w_m_re_x) || f_ovf(w_m_im_x)
                     || f_ovf(w_a_re_x) || f_ovf(w_a_im_x);

    // unwritten entries read as zero through the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
        end else if (i_cmd.load && w_load_ok) begin
            r_cvld[chpe_pkg::ADDR_W'(i_index)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_cre[chpe_pkg::ADDR_W'(i_index)] <= i_value_re;
            r_cim[chpe_pkg::ADDR_W'(i_index)] <= i_value_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
        end else if (i_cmd.cfg_wr) begin
            r_degree <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_z_re   <= i_value_re;
            r_z_im   <= i_value_im;
            r_res_re <= '0;
            r_res_im <= '0;
            r_ovf    <= 1'b0;
            r_k      <= w_top;
        end
        if (i_cmd.mul) begin
            r_p_rr <= r_res_re * r_z_re;
            r_p_ii <= r_res_im * r_z_im;
            r_p_ri <= r_res_re * r_z_im;
            r_p_ir <= r_res_im * r_z_re;
            r_c_re <= r_cvld[r_k] ? r_cre[r_k] : '0;
            r_c_im <= r_cvld[r_k] ? r_cim[r_k] : '0;
        end
        if (i_cmd.acc) begin
            r_res_re <= f_sat(w_a_re_x);
            r_res_im <= f_sat(w_a_im_x);
            r_ovf    <= r_ovf || w_step_ovf;
            r_k      <= r_k - 1'b1;
        end
        if (i_cmd.put) begin
            o_result_re <= r_res_re;
            o_result_im <= r_res_im;
            o_overflow  <= r_ovf;
        end
    end

endmodule

### sv/complex_horner_polynomial_eval.sv
// top level of the complex horner polynomial evaluator
// depends on chpe_pkg, the three channel interfaces, chpe_ctrl and chpe_dp
//
//   channel   modport   payload
//   i_in      sink      operation, index, value_re, value_im
//   o_out     source    result_re, result_im, overflow
//   i_cfg     sink      data (degree)
//
// a load transaction gives no result
// an evaluate runs a multiply then add-and-saturate loop, one pass per power from
// the degree down to zero, before the result is put and the next input is accepted
// a finished result waits in the output register; a second evaluate may run
// meanwhile and holds in its last step until that register frees
// reset clears the degree, the coefficient valid bits and the handshake state
module complex_horner_polynomial_eval (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chpe_in_if.sink    i_in,
    chpe_out_if.source o_out,
    chpe_cfg_if.sink   i_cfg
);

    chpe_pkg::t_dp_cmd w_cmd;
    chpe_pkg::t_dp_sts w_sts;

    chpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    chpe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_data  (i_cfg.data),
        .i_index     (i_in.index),
        .i_value_re  (i_in.value_re),
        .i_value_im  (i_in.value_im),
        .o_result_re (o_out.result_re),
        .o_result_im (o_out.result_im),
        .o_overflow  (o_out.overflow)
    );

endmodule

### sv/chpe_checker.sv
// port-level checks of the evaluator, bound to the top level
// depends on chpe_pkg and complex_horner_polynomial_eval_defines.svh
`include "complex_horner_polynomial_eval_defines.svh"

module chpe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_op,
    input logic i_out_valid,
    input logic i_out_ready
);

    logic w_eval_acc;
    logic w_load_acc;

    assign w_eval_acc = i_in_valid && i_in_ready && (i_in_op == chpe_pkg::OP_EVAL);
    assign w_load_acc = i_in_valid && i_in_ready && (i_in_op == chpe_pkg::OP_LOAD);

    // a pending result is not dropped
    `CHPE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // an evaluate occupies the block
    `CHPE_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, w_eval_acc, !i_in_ready)
    // a load never stalls the input
    `CHPE_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, w_load_acc, i_in_ready)
    // no result can appear right after an evaluate is taken
    `CHPE_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n, w_eval_acc, !$rose(i_out_valid))

endmodule

bind complex_horner_polynomial_eval chpe_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
